>>> hdl/blpw_pkg.sv
// Shared types and constants for the Bresenham line pixel writer.
// Holds the transaction payload structs, command and register codes and helpers.
// No dependencies.
package blpw_pkg;

   localparam int COORD_WIDTH = 16;
   localparam int DELTA_W     = COORD_WIDTH + 1;
   localparam int ERR_W       = COORD_WIDTH + 3;
   localparam int WIN_W       = 13;
   localparam int CMP_W       = (COORD_WIDTH > WIN_W) ? COORD_WIDTH : WIN_W;
   localparam int STRIDE_W    = 16;
   localparam int BPP_W       = 4;
   localparam int COLOR_W     = 32;
   localparam int OFFSET_W    = 28;
   localparam int PROD_W      = WIN_W + STRIDE_W;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 32;

   typedef enum logic {
      CMD_LOAD = 1'b0,
      CMD_STEP = 1'b1
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LINE_STRIDE     = 3'd0,
      CSR_BYTES_PER_PIXEL = 3'd1,
      CSR_ENDIAN_MODE     = 3'd2,
      CSR_LINE_COLOR      = 3'd3,
      CSR_WIN_WIDTH       = 3'd4,
      CSR_WIN_HEIGHT      = 3'd5
   } csr_idx_type;

   localparam logic [STRIDE_W-1:0] STRIDE_RESET = 16'd7680;
   localparam logic [BPP_W-1:0]    BPP_RESET    = 4'd4;
   localparam logic                ENDIAN_RESET = 1'b0;
   localparam logic [COLOR_W-1:0]  COLOR_RESET  = 32'd0;
   localparam logic [WIN_W-1:0]    WIDTH_RESET  = 13'd1920;
   localparam logic [WIN_W-1:0]    HEIGHT_RESET = 13'd1080;

   typedef struct packed {
      logic                          command;
      logic signed [COORD_WIDTH-1:0] start_x;
      logic signed [COORD_WIDTH-1:0] start_y;
      logic signed [COORD_WIDTH-1:0] end_x;
      logic signed [COORD_WIDTH-1:0] end_y;
   } req_type;

   typedef struct packed {
      logic [OFFSET_W-1:0] byte_offset;
      logic [COLOR_W-1:0]  pixel_word;
      logic                inside_res;
      logic                last;
   } rsp_type;

   // Pixel handed from the walker to the output pipeline; x and y are zero when outside.
   typedef struct packed {
      logic [WIN_W-1:0] x;
      logic [WIN_W-1:0] y;
      logic             in_win;
      logic             last;
   } pix_type;

   function automatic logic [COLOR_W-1:0] swap_bytes(input logic [COLOR_W-1:0] c);
      swap_bytes = {c[7:0], c[15:8], c[23:16], c[31:24]};
   endfunction

endpackage

>>> hdl/blpw_walker.sv
// Bresenham walker: holds the line state, sets it up on load and advances it on step.
// Presents the current pixel with window clipping. Depends on blpw_pkg.
module blpw_walker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       load_en,
   input  logic                       step_en,
   input  blpw_pkg::req_type          req_data,
   input  logic [blpw_pkg::WIN_W-1:0] win_width,
   input  logic [blpw_pkg::WIN_W-1:0] win_height,
   output blpw_pkg::pix_type          pix,
   output logic                       active
);
   import blpw_pkg::*;

   logic signed [COORD_WIDTH-1:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic signed [COORD_WIDTH-1:0] tgt_x_ff, tgt_x_in, tgt_y_ff, tgt_y_in;
   logic [DELTA_W-1:0]            dx_ff, dx_in, dy_ff, dy_in;
   logic                          dir_x_ff, dir_x_in, dir_y_ff, dir_y_in;
   logic signed [ERR_W-1:0]       err_ff, err_in;
   logic                          active_ff, active_in;

   // load setup
   logic signed [DELTA_W-1:0]     diff_x, diff_y;
   logic [DELTA_W-1:0]            abs_x, abs_y;
   logic signed [ERR_W-1:0]       err_load;

   // step
   logic signed [ERR_W:0]         twice, neg_dy, dx_wide;
   logic signed [ERR_W-1:0]       dx_e, dy_e;
   logic                          move_x, move_y;
   logic signed [COORD_WIDTH-1:0] nx, ny;
   logic signed [ERR_W-1:0]       err_step;

   // clipping
   logic [CMP_W-1:0]              x_cmp, y_cmp;
   logic                          in_window;

   always_comb begin
      diff_x = $signed({req_data.end_x[COORD_WIDTH-1], req_data.end_x})
             - $signed({req_data.start_x[COORD_WIDTH-1], req_data.start_x});
      diff_y = $signed({req_data.end_y[COORD_WIDTH-1], req_data.end_y})
             - $signed({req_data.start_y[COORD_WIDTH-1], req_data.start_y});
      abs_x  = diff_x[DELTA_W-1] ? DELTA_W'(-diff_x) : DELTA_W'(diff_x);
      abs_y  = diff_y[DELTA_W-1] ? DELTA_W'(-diff_y) : DELTA_W'(diff_y);
      err_load = $signed(ERR_W'(abs_x)) - $signed(ERR_W'(abs_y));

      dx_e    = $signed(ERR_W'(dx_ff));
      dy_e    = $signed(ERR_W'(dy_ff));
      twice   = $signed({err_ff, 1'b0});
      dx_wide = $signed((ERR_W+1)'(dx_ff));
      neg_dy  = -$signed((ERR_W+1)'(dy_ff));
      move_x  = twice > neg_dy;
      move_y  = twice < dx_wide;
      err_step = err_ff - (move_x ? dy_e : '0) + (move_y ? dx_e : '0);
      nx = move_x ? (dir_x_ff ? cur_x_ff + COORD_WIDTH'(1) : cur_x_ff - COORD_WIDTH'(1))
                  : cur_x_ff;
      ny = move_y ? (dir_y_ff ? cur_y_ff + COORD_WIDTH'(1) : cur_y_ff - COORD_WIDTH'(1))
                  : cur_y_ff;

      cur_x_in  = cur_x_ff;
      cur_y_in  = cur_y_ff;
      tgt_x_in  = tgt_x_ff;
      tgt_y_in  = tgt_y_ff;
      dx_in     = dx_ff;
      dy_in     = dy_ff;
      dir_x_in  = dir_x_ff;
      dir_y_in  = dir_y_ff;
      err_in    = err_ff;
      active_in = active_ff;

      priority if (load_en) begin
         cur_x_in  = req_data.start_x;
         cur_y_in  = req_data.start_y;
         tgt_x_in  = req_data.end_x;
         tgt_y_in  = req_data.end_y;
         dx_in     = abs_x;
         dy_in     = abs_y;
         dir_x_in  = req_data.start_x < req_data.end_x;
         dir_y_in  = req_data.start_y < req_data.end_y;
         err_in    = err_load;
         active_in = (req_data.start_x != req_data.end_x)
                  || (req_data.start_y != req_data.end_y);
      end else if (step_en) begin
         cur_x_in  = nx;
         cur_y_in  = ny;
         err_in    = err_step;
         // stop on reaching the end point; it is never plotted
         active_in = !((nx == tgt_x_ff) && (ny == tgt_y_ff));
      end else begin
         active_in = active_ff;
      end

      x_cmp  = CMP_W'($unsigned(cur_x_ff));
      y_cmp  = CMP_W'($unsigned(cur_y_ff));
      in_window = !cur_x_ff[COORD_WIDTH-1] && !cur_y_ff[COORD_WIDTH-1]
               && (x_cmp < CMP_W'(win_width)) && (y_cmp < CMP_W'(win_height));

      pix.x      = in_window ? x_cmp[WIN_W-1:0] : '0;
      pix.y      = in_window ? y_cmp[WIN_W-1:0] : '0;
      pix.in_win = in_window;
      pix.last   = !active_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff  <= '0;
         cur_y_ff  <= '0;
         tgt_x_ff  <= '0;
         tgt_y_ff  <= '0;
         dx_ff     <= '0;
         dy_ff     <= '0;
         dir_x_ff  <= 1'b0;
         dir_y_ff  <= 1'b0;
         err_ff    <= '0;
         active_ff <= 1'b0;
      end else begin
         cur_x_ff  <= cur_x_in;
         cur_y_ff  <= cur_y_in;
         tgt_x_ff  <= tgt_x_in;
         tgt_y_ff  <= tgt_y_in;
         dx_ff     <= dx_in;
         dy_ff     <= dy_in;
         dir_x_ff  <= dir_x_in;
         dir_y_ff  <= dir_y_in;
         err_ff    <= err_in;
         active_ff <= active_in;
      end
   end

   assign active = active_ff;

endmodule

>>> hdl/bresenham_line_pixel_writer_core.sv
// A step result is held in the clipped-pixel register, then in the output register.
// Throughput: one transaction per cycle unless the output is stalled; walker state
// updates in the accept cycle, and the offset multiply-add sits before the output register.
// Reset: synchronous; valid flags and CSRs return to defaults, the walker goes idle.
// Depends on blpw_pkg and blpw_walker.
module bresenham_line_pixel_writer_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  blpw_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output blpw_pkg::rsp_type               rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [blpw_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [blpw_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import blpw_pkg::*;

   logic [STRIDE_W-1:0] stride_ff, stride_in;
   logic [BPP_W-1:0]    bpp_ff, bpp_in;
   logic                endian_ff, endian_in;
   logic [COLOR_W-1:0]  color_ff, color_in;
   logic [WIN_W-1:0]    width_ff, width_in;
   logic [WIN_W-1:0]    height_ff, height_in;

   logic    req_accept, load_en, step_en, walk_active, out_ready;
   pix_type walk_pix;

   logic    pix_valid_ff, pix_valid_in;
   pix_type pix_ff, pix_in;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic [PROD_W-1:0] prod_y, prod_x, offset_sum;

   // configuration writes
   assign csr_ready = 1'b1;

   always_comb begin
      stride_in = stride_ff;
      bpp_in    = bpp_ff;
      endian_in = endian_ff;
      color_in  = color_ff;
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_valid) begin
         unique case (csr_idx_type'(csr_index))
            CSR_LINE_STRIDE:     stride_in = csr_wdata[STRIDE_W-1:0];
            CSR_BYTES_PER_PIXEL: bpp_in    = csr_wdata[BPP_W-1:0];
            CSR_ENDIAN_MODE:     endian_in = csr_wdata[0];
            CSR_LINE_COLOR:      color_in  = csr_wdata[COLOR_W-1:0];
            CSR_WIN_WIDTH:       width_in  = csr_wdata[WIN_W-1:0];
            CSR_WIN_HEIGHT:      height_in = csr_wdata[WIN_W-1:0];
            default: begin
               // drop writes beyond the register list
               stride_in = stride_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stride_ff <= STRIDE_RESET;
         bpp_ff    <= BPP_RESET;
         endian_ff <= ENDIAN_RESET;
         color_ff  <= COLOR_RESET;
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else begin
         stride_ff <= stride_in;
         bpp_ff    <= bpp_in;
         endian_ff <= endian_in;
         color_ff  <= color_in;
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // handshake: the pipeline advances whenever the output register can take data
   assign out_ready  = !rsp_valid_ff || rsp_ready;
   assign req_ready  = !pix_valid_ff || out_ready;
   assign req_accept = req_valid && req_ready;
   assign load_en    = req_accept && (cmd_type'(req_data.command) == CMD_LOAD);
   assign step_en    = req_accept && (cmd_type'(req_data.command) == CMD_STEP) && walk_active;

   blpw_walker u_walker (
      .clock      (clock),
      .reset      (reset),
      .load_en    (load_en),
      .step_en    (step_en),
      .req_data   (req_data),
      .win_width  (width_ff),
      .win_height (height_ff),
      .pix        (walk_pix),
      .active     (walk_active)
   );

   always_comb begin
      pix_valid_in = pix_valid_ff;
      pix_in       = pix_ff;
      if (req_ready) begin
         pix_valid_in = step_en;
         pix_in       = walk_pix;
      end

      prod_y     = PROD_W'(pix_ff.y) * PROD_W'(stride_ff);
      prod_x     = PROD_W'(pix_ff.x) * PROD_W'(bpp_ff);
      offset_sum = prod_y + prod_x;

      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (out_ready) begin
         rsp_valid_in       = pix_valid_ff;
         rsp_in.byte_offset = offset_sum[OFFSET_W-1:0];
         rsp_in.pixel_word  = !pix_ff.in_win ? '0
                            : (endian_ff ? swap_bytes(color_ff) : color_ff);
         rsp_in.inside_res  = pix_ff.in_win;
         rsp_in.last        = pix_ff.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pix_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pix_valid_ff <= pix_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pix_ff <= pix_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
